// ----- hw/rtl/tekd_pkg.sv -----
// tekd_pkg: types, command codes, byte constants and key tables for the
// terminal escape key decoder; no dependencies
package tekd_pkg;

   typedef logic [1:0]  kind_type;
   typedef logic [7:0]  byte_type;
   typedef logic [4:0]  cmd_type;
   typedef logic [16:0] acc_type;
   typedef logic [2:0]  count_type;

   // event kinds
   localparam kind_type KIND_BYTE = 2'd0;
   localparam kind_type KIND_WAIT = 2'd1;
   localparam kind_type KIND_END  = 2'd2;

   // command codes
   localparam cmd_type CMD_NONE    = 5'd0;
   localparam cmd_type CMD_FWD     = 5'd1;
   localparam cmd_type CMD_BACK    = 5'd2;
   localparam cmd_type CMD_LEFT    = 5'd3;
   localparam cmd_type CMD_RIGHT   = 5'd4;
   localparam cmd_type CMD_ASCEND  = 5'd5;
   localparam cmd_type CMD_PAUSE   = 5'd6;
   localparam cmd_type CMD_ALT     = 5'd7;
   localparam cmd_type CMD_RESTART = 5'd8;
   localparam cmd_type CMD_QUIT    = 5'd9;
   localparam cmd_type CMD_OPT1    = 5'd10;
   localparam cmd_type CMD_TRIM_PU = 5'd13;
   localparam cmd_type CMD_TRIM_PD = 5'd14;
   localparam cmd_type CMD_TRIM_RL = 5'd15;
   localparam cmd_type CMD_TRIM_RR = 5'd16;
   localparam cmd_type CMD_SAVE    = 5'd17;
   localparam cmd_type CMD_LOAD    = 5'd18;
   localparam cmd_type CMD_UNKNOWN = 5'd19;

   // function key numbers of the csi numeric form
   localparam acc_type FKEY_TRIM_PU = 17'd11;
   localparam acc_type FKEY_TRIM_PD = 17'd12;
   localparam acc_type FKEY_TRIM_RL = 17'd13;
   localparam acc_type FKEY_TRIM_RR = 17'd14;
   localparam acc_type FKEY_SAVE    = 17'd15;
   localparam acc_type FKEY_LOAD    = 17'd20;

   localparam count_type MAX_DIGITS = 3'd5;

   // bytes of interest
   localparam byte_type CH_ESC      = 8'h1B;
   localparam byte_type CH_SPACE    = 8'h20;
   localparam byte_type CH_ZERO     = 8'h30;
   localparam byte_type CH_ONE      = 8'h31;
   localparam byte_type CH_THREE    = 8'h33;
   localparam byte_type CH_NINE     = 8'h39;
   localparam byte_type CH_UP_A     = 8'h41;
   localparam byte_type CH_UP_B     = 8'h42;
   localparam byte_type CH_UP_C     = 8'h43;
   localparam byte_type CH_UP_D     = 8'h44;
   localparam byte_type CH_UP_H     = 8'h48;
   localparam byte_type CH_UP_O     = 8'h4F;
   localparam byte_type CH_UP_P     = 8'h50;
   localparam byte_type CH_UP_R     = 8'h52;
   localparam byte_type CH_UP_S     = 8'h53;
   localparam byte_type CH_UP_W     = 8'h57;
   localparam byte_type CH_UP_X     = 8'h58;
   localparam byte_type CH_LBRACKET = 8'h5B;
   localparam byte_type CH_LO_A     = 8'h61;
   localparam byte_type CH_LO_D     = 8'h64;
   localparam byte_type CH_LO_H     = 8'h68;
   localparam byte_type CH_LO_P     = 8'h70;
   localparam byte_type CH_LO_R     = 8'h72;
   localparam byte_type CH_LO_S     = 8'h73;
   localparam byte_type CH_LO_W     = 8'h77;
   localparam byte_type CH_LO_X     = 8'h78;
   localparam byte_type CH_TILDE    = 8'h7E;

   typedef enum logic [2:0] {
      MODE_IDLE   = 3'd0,
      MODE_ESC    = 3'd1,
      MODE_SS3    = 3'd2,
      MODE_CSI    = 3'd3,
      MODE_DIGITS = 3'd4
   } mode_type;

   typedef struct packed {
      mode_type  mode;
      acc_type   acc;
      count_type count;
      logic      ended;
   } parse_state_type;

   typedef struct packed {
      logic    emit;
      cmd_type command;
   } decode_result_type;

   function automatic cmd_type plain_key(input byte_type b);
      cmd_type c;
      case (b) inside
         CH_UP_W, CH_LO_W: c = CMD_FWD;
         CH_UP_S, CH_LO_S: c = CMD_BACK;
         CH_UP_A, CH_LO_A: c = CMD_LEFT;
         CH_UP_D, CH_LO_D: c = CMD_RIGHT;
         CH_SPACE:         c = CMD_ASCEND;
         CH_UP_P, CH_LO_P: c = CMD_PAUSE;
         CH_UP_H, CH_LO_H: c = CMD_ALT;
         CH_UP_R, CH_LO_R: c = CMD_RESTART;
         CH_UP_X, CH_LO_X: c = CMD_QUIT;
         // '1' '2' '3' sit at low bits 1..3
         [CH_ONE:CH_THREE]: c = CMD_OPT1 + cmd_type'(b[1:0]) - 5'd1;
         default:          c = CMD_UNKNOWN;
      endcase
      return c;
   endfunction

   function automatic cmd_type arrow_key(input byte_type b);
      cmd_type c;
      case (b)
         CH_UP_A: c = CMD_FWD;
         CH_UP_B: c = CMD_BACK;
         CH_UP_C: c = CMD_RIGHT;
         CH_UP_D: c = CMD_LEFT;
         default: c = CMD_NONE;
      endcase
      return c;
   endfunction

   function automatic cmd_type function_key(input acc_type code);
      cmd_type c;
      case (code)
         FKEY_TRIM_PU: c = CMD_TRIM_PU;
         FKEY_TRIM_PD: c = CMD_TRIM_PD;
         FKEY_TRIM_RL: c = CMD_TRIM_RL;
         FKEY_TRIM_RR: c = CMD_TRIM_RR;
         FKEY_SAVE:    c = CMD_SAVE;
         FKEY_LOAD:    c = CMD_LOAD;
         default:      c = CMD_UNKNOWN;
      endcase
      return c;
   endfunction

   function automatic logic is_digit(input byte_type b);
      return (b >= CH_ZERO) && (b <= CH_NINE);
   endfunction

endpackage

// ----- hw/rtl/tekd_decode.sv -----
// tekd_decode: one-event decode of the escape parser, next parse state and
// optional command; depends on tekd_pkg
module tekd_decode (
   input  tekd_pkg::parse_state_type   state,
   input  tekd_pkg::kind_type          kind,
   input  tekd_pkg::byte_type          byte_value,
   output tekd_pkg::parse_state_type   state_next,
   output tekd_pkg::decode_result_type result
);
   import tekd_pkg::*;

   logic       have;
   logic [3:0] digit;
   acc_type    acc_times_ten;
   count_type  count_plus;
   cmd_type    arrow;

   assign have          = (kind == KIND_BYTE);
   // '0'..'9' carry their value in the low nibble
   assign digit         = byte_value[3:0];
   // acc * 10 as (acc << 3) + (acc << 1), wrapping at 17 bits
   assign acc_times_ten = {state.acc[13:0], 3'b000} + {state.acc[15:0], 1'b0};
   assign count_plus    = state.count + 3'd1;
   assign arrow         = arrow_key(byte_value);

   always_comb begin
      logic    go_idle;
      cmd_type cmd;
      go_idle    = 1'b1;
      cmd        = CMD_UNKNOWN;
      state_next = state;

      if (state.ended || kind == KIND_END) begin
         cmd              = CMD_QUIT;
         state_next.ended = 1'b1;
      end else begin
         unique case (state.mode)
            MODE_ESC: begin
               if (!have) begin
                  cmd = CMD_QUIT;
               end else if (byte_value == CH_UP_O) begin
                  go_idle         = 1'b0;
                  state_next.mode = MODE_SS3;
               end else if (byte_value == CH_LBRACKET) begin
                  go_idle         = 1'b0;
                  state_next.mode = MODE_CSI;
               end
            end
            MODE_SS3: begin
               if (have) begin
                  if (byte_value >= CH_UP_P && byte_value <= CH_UP_S) begin
                     cmd = CMD_TRIM_PU + cmd_type'(byte_value[1:0]);
                  end else if (arrow != CMD_NONE) begin
                     cmd = arrow;
                  end
               end
            end
            MODE_CSI: begin
               if (have) begin
                  if (arrow != CMD_NONE) begin
                     cmd = arrow;
                  end else if (is_digit(byte_value)) begin
                     go_idle          = 1'b0;
                     state_next.mode  = MODE_DIGITS;
                     state_next.acc   = acc_type'(digit);
                     state_next.count = 3'd1;
                  end
               end
            end
            MODE_DIGITS: begin
               if (have) begin
                  if (byte_value == CH_TILDE) begin
                     cmd = function_key(state.acc);
                  end else if (is_digit(byte_value)) begin
                     // fifth digit overflows: unknown
                     if (count_plus < MAX_DIGITS) begin
                        go_idle          = 1'b0;
                        state_next.acc   = acc_times_ten + acc_type'(digit);
                        state_next.count = count_plus;
                     end
                  end
               end
            end
            default: begin
               if (!have) begin
                  cmd = CMD_NONE;
               end else if (byte_value == CH_ESC) begin
                  go_idle         = 1'b0;
                  state_next.mode = MODE_ESC;
               end else begin
                  cmd = plain_key(byte_value);
               end
            end
         endcase
      end

      if (go_idle) begin
         state_next.mode  = MODE_IDLE;
         state_next.acc   = '0;
         state_next.count = '0;
      end
      result.emit    = go_idle;
      result.command = cmd;
   end

endmodule

// ----- hw/rtl/terminal_escape_key_decoder.sv -----
// terminal_escape_key_decoder: top level, request register, parse state and
// response register around tekd_decode; depends on tekd_pkg, tekd_decode
//
// usage
//   request channel: req_valid/req_ready with req_kind (byte, wait expired,
//   end of input) and req_byte_value; one keyboard event per request
//   response channel: rsp_valid/rsp_ready with rsp_command; each request
//   gives zero or one response (bytes that open or continue an escape
//   sequence give none)
//   path: a taken request is held in the request register, then decoded into
//   the response register once the response slot is free
//   throughput: one request per cycle while no response stall holds it,
//   set by the single decode pass; the parse state updates in the same
//   cycle the decoded item leaves the request register
//   stall: while rsp_valid is high and rsp_ready low, the response holds;
//   the request register still takes one more request, then req_ready drops
//   until the response is taken
//   reset: synchronous, active high; clears both valid bits and the parse
//   state (idle, no digits, end of input not seen)
//   after end of input every later request answers quit
module terminal_escape_key_decoder (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  tekd_pkg::kind_type req_kind,
   input  tekd_pkg::byte_type req_byte_value,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output tekd_pkg::cmd_type  rsp_command
);
   import tekd_pkg::*;

   // request register
   logic            in_valid_ff, in_valid_in;
   kind_type        in_kind_ff;
   byte_type        in_byte_ff;

   // parse state
   parse_state_type state_ff, state_in;

   // response register
   logic            rsp_valid_ff, rsp_valid_in;
   cmd_type         rsp_command_ff, rsp_command_in;

   parse_state_type   state_next;
   decode_result_type result;
   logic              req_fire;
   logic              stage_fire;

   tekd_decode u_decode (
      .state      (state_ff),
      .kind       (in_kind_ff),
      .byte_value (in_byte_ff),
      .state_next (state_next),
      .result     (result)
   );

   // decoded item leaves the request register when the response slot is free
   assign stage_fire = in_valid_ff && (!rsp_valid_ff || rsp_ready);
   assign req_ready  = !in_valid_ff || stage_fire;
   assign req_fire   = req_valid && req_ready;

   always_comb begin
      in_valid_in = in_valid_ff;
      if (req_fire) begin
         in_valid_in = 1'b1;
      end else if (stage_fire) begin
         in_valid_in = 1'b0;
      end
   end

   always_comb begin
      state_in = stage_fire ? state_next : state_ff;
   end

   always_comb begin
      rsp_valid_in   = rsp_valid_ff;
      rsp_command_in = rsp_command_ff;
      if (stage_fire) begin
         rsp_valid_in = result.emit;
         if (result.emit) begin
            rsp_command_in = result.command;
         end
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         state_ff     <= '{mode: MODE_IDLE, acc: '0, count: '0, ended: 1'b0};
      end else begin
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         state_ff     <= state_in;
      end
   end

   // payload, no reset
   always_ff @(posedge clock) begin
      if (req_fire) begin
         in_kind_ff <= req_kind;
         in_byte_ff <= req_byte_value;
      end
      rsp_command_ff <= rsp_command_in;
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_command = rsp_command_ff;

`ifndef SYNTHESIS
   // end of input is sticky
   a_ended_sticky: assert property (@(posedge clock) disable iff (reset)
      state_ff.ended |=> state_ff.ended)
      else $error("end of input flag cleared");

   // once ended, every decoded request answers quit
   a_ended_quit: assert property (@(posedge clock) disable iff (reset)
      (stage_fire && state_ff.ended) |=> (rsp_valid_ff && rsp_command_ff == CMD_QUIT))
      else $error("request after end of input did not answer quit");

   // digits counted only while gathering csi digits
   a_count_mode: assert property (@(posedge clock) disable iff (reset)
      (state_ff.count != 3'd0) |-> (state_ff.mode == MODE_DIGITS))
      else $error("digit count outside digit mode");

   // parser rests idle after end of input
   a_ended_idle: assert property (@(posedge clock) disable iff (reset)
      state_ff.ended |-> (state_ff.mode == MODE_IDLE))
      else $error("parser left idle after end of input");

   // a held response is never overwritten
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_ready) |=> (rsp_valid_ff && $stable(rsp_command_ff)))
      else $error("stalled response changed");
`endif

endmodule

// ----- tb/terminal_escape_key_decoder_checker.sv -----
// terminal_escape_key_decoder_checker: watches both channels of the key decoder,
// predicts the command for each accepted request and compares responses in order
// depends on tekd_pkg
module terminal_escape_key_decoder_checker (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   input  logic               req_ready,
   input  tekd_pkg::kind_type req_kind,
   input  tekd_pkg::byte_type req_byte_value,
   input  logic               rsp_valid,
   input  logic               rsp_ready,
   input  tekd_pkg::cmd_type  rsp_command,
   output int                 mismatch_count,
   output int                 responses_pending
);
   import tekd_pkg::*;

   mode_type  parse_mode;
   acc_type   code_acc;
   count_type digits_seen;
   logic      input_ended;

   cmd_type   expected_cmds [$];
   int        mismatches;

   function automatic cmd_type key_table_cmd(input byte_type b);
      cmd_type c;
      case (b)
         CH_UP_W, CH_LO_W: c = CMD_FWD;
         CH_UP_S, CH_LO_S: c = CMD_BACK;
         CH_UP_A, CH_LO_A: c = CMD_LEFT;
         CH_UP_D, CH_LO_D: c = CMD_RIGHT;
         CH_SPACE:         c = CMD_ASCEND;
         CH_UP_P, CH_LO_P: c = CMD_PAUSE;
         CH_UP_H, CH_LO_H: c = CMD_ALT;
         CH_UP_R, CH_LO_R: c = CMD_RESTART;
         CH_UP_X, CH_LO_X: c = CMD_QUIT;
         default: begin
            if (b >= CH_ONE && b <= CH_THREE)
               c = cmd_type'(CMD_OPT1 + (b - CH_ONE));
            else
               c = CMD_UNKNOWN;
         end
      endcase
      return c;
   endfunction

   function automatic cmd_type cursor_cmd(input byte_type b);
      cmd_type c;
      case (b)
         CH_UP_A: c = CMD_FWD;
         CH_UP_B: c = CMD_BACK;
         CH_UP_C: c = CMD_RIGHT;
         CH_UP_D: c = CMD_LEFT;
         default: c = CMD_NONE;
      endcase
      return c;
   endfunction

   function automatic cmd_type fkey_cmd(input acc_type code);
      cmd_type c;
      case (code)
         FKEY_TRIM_PU: c = CMD_TRIM_PU;
         FKEY_TRIM_PD: c = CMD_TRIM_PD;
         FKEY_TRIM_RL: c = CMD_TRIM_RL;
         FKEY_TRIM_RR: c = CMD_TRIM_RR;
         FKEY_SAVE:    c = CMD_SAVE;
         FKEY_LOAD:    c = CMD_LOAD;
         default:      c = CMD_UNKNOWN;
      endcase
      return c;
   endfunction

   // advances the parse state by one event; returns 1 when a command comes out
   function automatic logic decode_key_event(input kind_type kind, input byte_type b,
                                             output cmd_type cmd);
      logic have;
      have = (kind == KIND_BYTE);
      cmd = CMD_UNKNOWN;
      if (input_ended || kind == KIND_END) begin
         input_ended = 1'b1;
         parse_mode  = MODE_IDLE;
         code_acc    = '0;
         digits_seen = '0;
         cmd = CMD_QUIT;
         return 1'b1;
      end
      case (parse_mode)
         MODE_ESC: begin
            if (!have) begin
               cmd = CMD_QUIT;
            end else if (b == CH_UP_O) begin
               parse_mode = MODE_SS3;
               return 1'b0;
            end else if (b == CH_LBRACKET) begin
               parse_mode = MODE_CSI;
               return 1'b0;
            end
         end
         MODE_SS3: begin
            if (have) begin
               if (b >= CH_UP_P && b <= CH_UP_S)
                  cmd = cmd_type'(CMD_TRIM_PU + (b - CH_UP_P));
               else if (cursor_cmd(b) != CMD_NONE)
                  cmd = cursor_cmd(b);
            end
         end
         MODE_CSI: begin
            if (have) begin
               if (cursor_cmd(b) != CMD_NONE) begin
                  cmd = cursor_cmd(b);
               end else if (b >= CH_ZERO && b <= CH_NINE) begin
                  code_acc    = acc_type'(b - CH_ZERO);
                  digits_seen = count_type'(1);
                  parse_mode  = MODE_DIGITS;
                  return 1'b0;
               end
            end
         end
         MODE_DIGITS: begin
            if (have) begin
               if (b == CH_TILDE) begin
                  cmd = fkey_cmd(code_acc);
               end else if (b >= CH_ZERO && b <= CH_NINE) begin
                  code_acc    = acc_type'(code_acc * 10 + (b - CH_ZERO));
                  digits_seen = count_type'(digits_seen + 1);
                  if (digits_seen < MAX_DIGITS)
                     return 1'b0;
               end
            end
         end
         default: begin
            if (!have) begin
               cmd = CMD_NONE;
            end else if (b == CH_ESC) begin
               parse_mode = MODE_ESC;
               return 1'b0;
            end else begin
               cmd = key_table_cmd(b);
            end
         end
      endcase
      parse_mode  = MODE_IDLE;
      code_acc    = '0;
      digits_seen = '0;
      return 1'b1;
   endfunction

   always @(posedge clock) begin : watch
      cmd_type want;
      logic    emits;
      if (reset) begin
         parse_mode  = MODE_IDLE;
         code_acc    = '0;
         digits_seen = '0;
         input_ended = 1'b0;
         expected_cmds.delete();
         mismatches  = 0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (expected_cmds.size() == 0) begin
               $error("command: no response expected, got %0d", rsp_command);
               mismatches++;
            end else begin
               want = expected_cmds.pop_front();
               if (rsp_command !== want) begin
                  $error("command: expected %0d, actual %0d", want, rsp_command);
                  mismatches++;
               end
            end
         end
         if (req_valid && req_ready) begin
            emits = decode_key_event(req_kind, req_byte_value, want);
            if (emits)
               expected_cmds.push_back(want);
         end
      end
      mismatch_count    <= mismatches;
      responses_pending <= expected_cmds.size();
   end

endmodule

// ----- tb/terminal_escape_key_decoder_tb.sv -----
// terminal_escape_key_decoder_tb: clock, reset and keyboard event stimulus for the
// key decoder with random gaps and response stalls; verdict from the checker
// depends on tekd_pkg, terminal_escape_key_decoder, terminal_escape_key_decoder_checker
module terminal_escape_key_decoder_tb;
   import tekd_pkg::*;

   // kind code 3 is not named by the block; it must act like an expired wait
   localparam kind_type KIND_SPARE    = 2'd3;
   localparam int       RANDOM_EVENTS = 1550;
   localparam int       CYCLE_LIMIT   = 500000;

   logic     clock;
   logic     reset;
   logic     req_valid;
   logic     req_ready;
   kind_type req_kind;
   byte_type req_byte_value;
   logic     rsp_valid;
   logic     rsp_ready;
   cmd_type  rsp_command;

   int mismatch_count;
   int responses_pending;
   int events_sent;
   int steady_left;
   int cycle_count;

   // bytes with a meaning of their own in the plain key table
   byte_type plain_keys [20] = '{CH_UP_W, CH_LO_W, CH_UP_S, CH_LO_S, CH_UP_A, CH_LO_A,
                                 CH_UP_D, CH_LO_D, CH_SPACE, CH_UP_P, CH_LO_P, CH_UP_H,
                                 CH_LO_H, CH_UP_R, CH_LO_R, CH_UP_X, CH_LO_X, CH_ONE,
                                 byte_type'(CH_ONE + 8'd1), CH_THREE};
   acc_type  fkey_codes [6]  = '{FKEY_TRIM_PU, FKEY_TRIM_PD, FKEY_TRIM_RL, FKEY_TRIM_RR,
                                 FKEY_SAVE, FKEY_LOAD};

   terminal_escape_key_decoder u_dut (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_kind       (req_kind),
      .req_byte_value (req_byte_value),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_command    (rsp_command)
   );

   terminal_escape_key_decoder_checker u_checker (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_kind          (req_kind),
      .req_byte_value    (req_byte_value),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_command       (rsp_command),
      .mismatch_count    (mismatch_count),
      .responses_pending (responses_pending)
   );

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   // offers one request at a falling edge, holds it until taken, then maybe idles
   task automatic send_event(input kind_type kind, input byte_type value);
      int gap;
      int pick;
      @(negedge clock);
      req_valid      <= 1'b1;
      req_kind       <= kind;
      req_byte_value <= value;
      do @(posedge clock); while (req_ready !== 1'b1);
      events_sent++;
      // mostly back to back, some short gaps, a few long ones, now and then a
      // stretch with no gaps at all
      pick = $urandom_range(0, 99);
      if (steady_left > 0) begin
         steady_left--;
         gap = 0;
      end else if (pick < 4) begin
         steady_left = $urandom_range(30, 60);
         gap = 0;
      end else if (pick < 55) begin
         gap = 0;
      end else if (pick < 90) begin
         gap = $urandom_range(1, 3);
      end else begin
         gap = $urandom_range(8, 30);
      end
      if (gap > 0) begin
         @(negedge clock);
         req_valid <= 1'b0;
         repeat (gap - 1) @(negedge clock);
      end
   endtask

   // response side: runs of ready and short stalls, two long hold-offs so the
   // request side backs up and drops req_ready
   initial begin : response_sink
      int   run_len;
      int   pick;
      int   sink_cycles;
      int   holds_done;
      logic level;
      rsp_ready   = 1'b0;
      sink_cycles = 0;
      holds_done  = 0;
      forever begin
         pick = $urandom_range(0, 99);
         if ((sink_cycles > 300 && holds_done == 0) ||
             (sink_cycles > 3000 && holds_done == 1)) begin
            level   = 1'b0;
            run_len = $urandom_range(150, 250);
            holds_done++;
         end else if (pick < 55) begin
            level   = 1'b1;
            run_len = $urandom_range(1, 24);
         end else if (pick < 93) begin
            level   = 1'b0;
            run_len = $urandom_range(1, 3);
         end else begin
            level   = 1'b0;
            run_len = $urandom_range(8, 40);
         end
         @(negedge clock);
         rsp_ready <= level;
         repeat (run_len - 1) @(negedge clock);
         sink_cycles += run_len;
      end
   end

   // watchdog
   initial begin
      cycle_count = 0;
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("Mismatches found");
      $finish;
   end

   initial begin : stimulus
      int       pick;
      int       ndig;
      int       code;
      int       div;
      int       i;
      byte_type fin;
      reset          = 1'b1;
      req_valid      = 1'b0;
      req_kind       = KIND_BYTE;
      req_byte_value = '0;
      events_sent    = 0;
      steady_left    = 0;
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // directed: idle wait and the spare kind give none, byte extremes are unknown
      send_event(KIND_WAIT, 8'h00);
      send_event(KIND_SPARE, 8'hFF);
      send_event(KIND_BYTE, 8'h00);
      send_event(KIND_BYTE, 8'hFF);
      // lone esc gives quit
      send_event(KIND_BYTE, CH_ESC);
      send_event(KIND_WAIT, 8'h00);
      // wait expiring after ss3 gives unknown
      send_event(KIND_BYTE, CH_ESC);
      send_event(KIND_BYTE, CH_UP_O);
      send_event(KIND_WAIT, 8'h00);
      // unexpected byte after esc is swallowed as unknown
      send_event(KIND_BYTE, CH_ESC);
      send_event(KIND_BYTE, CH_LO_W);
      // leading zero kept by value: esc [ 0 1 1 ~ is the first trim key
      send_event(KIND_BYTE, CH_ESC);
      send_event(KIND_BYTE, CH_LBRACKET);
      send_event(KIND_BYTE, CH_ZERO);
      send_event(KIND_BYTE, CH_ONE);
      send_event(KIND_BYTE, CH_ONE);
      send_event(KIND_BYTE, CH_TILDE);
      // fifth digit ends the code as unknown right away
      send_event(KIND_BYTE, CH_ESC);
      send_event(KIND_BYTE, CH_LBRACKET);
      for (i = 0; i < 5; i++)
         send_event(KIND_BYTE, byte_type'(CH_ONE + i));
      send_event(KIND_BYTE, CH_NINE);

      // random part: mostly well-formed sequences with random content, some noise;
      // end of input is held back, it would make every later request quit
      events_sent = 0;
      while (events_sent < RANDOM_EVENTS) begin
         pick = $urandom_range(0, 99);
         if (pick < 14) begin
            if ($urandom_range(0, 9) < 7)
               send_event(KIND_BYTE, plain_keys[$urandom_range(0, 19)]);
            else
               send_event(KIND_BYTE, byte_type'($urandom_range(0, 255)));
         end else if (pick < 20) begin
            send_event(($urandom_range(0, 1) == 0) ? KIND_WAIT : KIND_SPARE,
                       byte_type'($urandom_range(0, 255)));
         end else if (pick < 28) begin
            send_event(KIND_BYTE, CH_ESC);
            if ($urandom_range(0, 1) == 0)
               send_event(KIND_WAIT, byte_type'($urandom_range(0, 255)));
            else
               send_event(KIND_BYTE, byte_type'($urandom_range(0, 255)));
         end else if (pick < 48) begin
            // ss3: trims and cursor keys
            send_event(KIND_BYTE, CH_ESC);
            send_event(KIND_BYTE, CH_UP_O);
            pick = $urandom_range(0, 99);
            if (pick < 50)
               send_event(KIND_BYTE, byte_type'(CH_UP_P + $urandom_range(0, 3)));
            else if (pick < 80)
               send_event(KIND_BYTE, byte_type'(CH_UP_A + $urandom_range(0, 3)));
            else if (pick < 90)
               send_event(KIND_BYTE, byte_type'($urandom_range(0, 255)));
            else
               send_event(KIND_WAIT, byte_type'($urandom_range(0, 255)));
         end else if (pick < 63) begin
            // csi cursor keys
            send_event(KIND_BYTE, CH_ESC);
            send_event(KIND_BYTE, CH_LBRACKET);
            pick = $urandom_range(0, 99);
            if (pick < 85)
               send_event(KIND_BYTE, byte_type'(CH_UP_A + $urandom_range(0, 3)));
            else if (pick < 93)
               send_event(KIND_BYTE, byte_type'($urandom_range(0, 255)));
            else
               send_event(KIND_SPARE, byte_type'($urandom_range(0, 255)));
         end else if (pick < 92) begin
            // csi numeric code, its low digits zero padded to the digit count
            if ($urandom_range(0, 99) < 60) begin
               code = int'(fkey_codes[$urandom_range(0, 5)]);
               ndig = $urandom_range(2, 4);
            end else begin
               code = int'($urandom_range(0, 99999));
               ndig = $urandom_range(1, 5);
            end
            div = 1;
            repeat (ndig - 1) div *= 10;
            send_event(KIND_BYTE, CH_ESC);
            send_event(KIND_BYTE, CH_LBRACKET);
            for (i = 0; i < ndig; i++) begin
               send_event(KIND_BYTE, byte_type'(CH_ZERO + (code / div) % 10));
               div /= 10;
            end
            pick = $urandom_range(0, 99);
            if (pick < 80)
               fin = CH_TILDE;
            else
               fin = byte_type'($urandom_range(0, 255));
            if (pick < 90)
               send_event(KIND_BYTE, fin);
            else
               send_event(KIND_WAIT, fin);
         end else begin
            // noise in any kind but end of input
            case ($urandom_range(0, 2))
               0:       send_event(KIND_BYTE, byte_type'($urandom_range(0, 255)));
               1:       send_event(KIND_WAIT, byte_type'($urandom_range(0, 255)));
               default: send_event(KIND_SPARE, byte_type'($urandom_range(0, 255)));
            endcase
         end
      end

      // end of input, then everything after it must answer quit
      send_event(KIND_END, byte_type'($urandom_range(0, 255)));
      repeat (20) send_event(kind_type'($urandom_range(0, 3)),
                             byte_type'($urandom_range(0, 255)));

      // stop offering once the last request is taken
      @(negedge clock);
      req_valid <= 1'b0;

      // drain: let the checker see every expected response, then a few more cycles
      @(posedge clock);
      while (responses_pending != 0) @(posedge clock);
      repeat (4) @(posedge clock);
      if (mismatch_count == 0)
         $display("No mismatches found");
      else
         $display("Mismatches found");
      $finish;
   end

endmodule
